@@ sv/bft_pkg.sv @@
// shared types and constants for the barycentric triangle fill block
// used by barycentric_triangle_fill and its checker; no dependencies
package bft_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 8;

  // field widths of the stream words
  localparam int COORD_FIELD_W  = 12;
  localparam int VALUE_W        = 16;
  localparam int CORNER_W       = 8;
  localparam int IN_TDATA_W     = 40;
  localparam int OUT_TDATA_W    = 16;
  localparam int OUT_TUSER_W    = 2;

  // config port
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 24;

  // flag positions in the output tuser
  localparam int USER_FILLED    = 0;
  localparam int USER_DEGEN     = 1;

  localparam logic [VALUE_W-1:0] VALUE_MAX = 16'hFFFF;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_VERTEX_A_X    = 3'd0,
    REG_VERTEX_A_Y    = 3'd1,
    REG_VERTEX_B_X    = 3'd2,
    REG_VERTEX_B_Y    = 3'd3,
    REG_VERTEX_C_X    = 3'd4,
    REG_VERTEX_C_Y    = 3'd5,
    REG_CORNER_VALUES = 3'd6
  } cfg_reg_t;

endpackage

@@ sv/barycentric_triangle_fill.sv @@
// barycentric triangle fill: per-pixel inside test and blended fill value
// depends on bft_pkg; checked by bft_checker (bound from its own file)
//
//   channel   direction  handshake          payload
//   s_*       in         tvalid / tready    tdata: pixel_x, pixel_y, current_value
//   m_*       out        tvalid / tready    tdata: new_value; tuser: was_filled, degenerate
//   cfg_*     in         cfg_we only        cfg_addr register index, cfg_wdata value
//
// one word per cycle sustained while the output is not stalled; the pipe depth is set mostly
// by the restoring divider that resolves one quotient bit per stage
// rst is synchronous and clears all stage valid bits and the config registers
// every stage has its own valid bit; a stage loads whenever a bubble sits at or
// after it, so a stalled output only blocks input once the whole pipe is full
module barycentric_triangle_fill #(
  parameter int COORD_BITS = bft_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = bft_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // input pixel stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [bft_pkg::IN_TDATA_W-1:0]     s_tdata,   // pixel_x[11:0], pixel_y[23:12],
                                                        // current_value[39:24]
  // output pixel stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [bft_pkg::OUT_TDATA_W-1:0]    m_tdata,   // new_value[15:0]
  output logic [bft_pkg::OUT_TUSER_W-1:0]    m_tuser,   // was_filled[0], degenerate[1]
  // config write port
  input  logic                               cfg_we,
  input  logic [bft_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [bft_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int CW   = COORD_BITS;
  localparam int VIN  = (CW < bft_pkg::COORD_FIELD_W) ? CW : bft_pkg::COORD_FIELD_W;
  localparam int DF   = CW + 1;          // signed coordinate difference
  localparam int PW   = 2 * CW + 2;      // signed product and two-term sum
  localparam int N3W  = 2 * CW + 4;      // third weight before magnitude
  localparam int DW   = 2 * CW + 1;      // magnitudes of det and weights
  localparam int MW   = DW + bft_pkg::CORNER_W;  // weight times corner value
  localparam int SUMW = MW + 2;
  localparam int QB   = bft_pkg::CORNER_W + FRAC_BITS;  // quotient bits
  localparam int NW   = DW + QB;         // dividend width
  localparam int QW   = (QB > bft_pkg::VALUE_W) ? QB : bft_pkg::VALUE_W;
  localparam int NS   = 7 + QB;          // total pipeline stages
  localparam int VW   = bft_pkg::VALUE_W;

  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QB-1:0] low;        // dividend bits still to shift in, quotient bits behind
    logic [DW-1:0] dvs;
    logic [VW-1:0] pix_value;
    logic          filled;
    logic          degen;
  } div_t;

  // config registers
  logic [CW-1:0] vax, vay, vbx, vby, vcx, vcy;
  logic [3*bft_pkg::CORNER_W-1:0] corners;

  // pipeline control
  logic [NS-1:0] v;
  logic [NS-1:0] adv;

  // stage 0: differences
  logic [CW-1:0]        px, py;
  logic signed [DF-1:0] s0_dxp, s0_dyp, s0_ybc, s0_xcb, s0_yca, s0_xac, s0_yac;
  logic [VW-1:0]        s0_cur;

  // stage 1: products
  logic signed [PW-1:0] s1_pd0, s1_pd1, s1_pn10, s1_pn11, s1_pn20, s1_pn21;
  logic [VW-1:0]        s1_cur;

  // stage 2: det and the first two weights
  logic signed [PW-1:0] s2_det, s2_n1, s2_n2;
  logic [VW-1:0]        s2_cur;

  // stage 3: inside test and magnitudes
  logic signed [N3W-1:0] n3;
  logic signed [N3W-1:0] n3_abs;
  logic                  n1_neg, n2_neg, n3_neg, n1_zero, n2_zero, n3_zero;
  logic                  in_tri, degen_c;
  logic [DW-1:0]         s3_d, s3_a1, s3_a2, s3_a3;
  logic [VW-1:0]         s3_cur;
  logic                  s3_filled, s3_degen;

  // stage 4: weighted corner values
  logic [MW-1:0]  s4_m1, s4_m2, s4_m3;
  logic [DW-1:0]  s4_d;
  logic [VW-1:0]  s4_cur;
  logic           s4_filled, s4_degen;

  // stage 5 and the divider chain
  logic [SUMW-1:0] num_sum;
  logic [NW-1:0]   dividend;
  div_t            dv [0:QB];

  // output stage
  logic [QW-1:0] q_ext;
  logic          q_sat;

  // ------------------------------------------------------------------
  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      vax     <= '0;
      vay     <= '0;
      vbx     <= '0;
      vby     <= '0;
      vcx     <= '0;
      vcy     <= '0;
      corners <= '0;
    end else if (cfg_we) begin
      case (bft_pkg::cfg_reg_t'(cfg_addr))
        bft_pkg::REG_VERTEX_A_X:    vax     <= CW'(cfg_wdata[VIN-1:0]);
        bft_pkg::REG_VERTEX_A_Y:    vay     <= CW'(cfg_wdata[VIN-1:0]);
        bft_pkg::REG_VERTEX_B_X:    vbx     <= CW'(cfg_wdata[VIN-1:0]);
        bft_pkg::REG_VERTEX_B_Y:    vby     <= CW'(cfg_wdata[VIN-1:0]);
        bft_pkg::REG_VERTEX_C_X:    vcx     <= CW'(cfg_wdata[VIN-1:0]);
        bft_pkg::REG_VERTEX_C_Y:    vcy     <= CW'(cfg_wdata[VIN-1:0]);
        bft_pkg::REG_CORNER_VALUES: corners <= cfg_wdata[3*bft_pkg::CORNER_W-1:0];
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // ------------------------------------------------------------------
  // stage k may load when any stage from k to the end holds a bubble,
  // or when the output word is taken
  always_comb begin
    for (int k = 0; k < NS; k++) begin
      adv[k] = m_tready | ~(&(v | ~({NS{1'b1}} << k)));
    end
  end

  assign s_tready = adv[0];
  assign m_tvalid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[0]) begin
        v[0] <= s_tvalid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // ------------------------------------------------------------------
  // stage 0: coordinate differences against the third vertex
  assign px = CW'(s_tdata[VIN-1:0]);
  assign py = CW'(s_tdata[bft_pkg::COORD_FIELD_W +: VIN]);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_dxp <= $signed({1'b0, px})  - $signed({1'b0, vcx});
      s0_dyp <= $signed({1'b0, py})  - $signed({1'b0, vcy});
      s0_ybc <= $signed({1'b0, vby}) - $signed({1'b0, vcy});
      s0_xcb <= $signed({1'b0, vcx}) - $signed({1'b0, vbx});
      s0_yca <= $signed({1'b0, vcy}) - $signed({1'b0, vay});
      s0_xac <= $signed({1'b0, vax}) - $signed({1'b0, vcx});
      s0_yac <= $signed({1'b0, vay}) - $signed({1'b0, vcy});
      s0_cur <= s_tdata[2*bft_pkg::COORD_FIELD_W +: VW];
    end
  end

  // stage 1: six products, one multiplier each
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_pd0  <= PW'(s0_ybc) * PW'(s0_xac);
      s1_pd1  <= PW'(s0_xcb) * PW'(s0_yac);
      s1_pn10 <= PW'(s0_ybc) * PW'(s0_dxp);
      s1_pn11 <= PW'(s0_xcb) * PW'(s0_dyp);
      s1_pn20 <= PW'(s0_yca) * PW'(s0_dxp);
      s1_pn21 <= PW'(s0_xac) * PW'(s0_dyp);
      s1_cur  <= s0_cur;
    end
  end

  // stage 2: determinant and two barycentric weights (the edge functions)
  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_det <= s1_pd0 + s1_pd1;
      s2_n1  <= s1_pn10 + s1_pn11;
      s2_n2  <= s1_pn20 + s1_pn21;
      s2_cur <= s1_cur;
    end
  end

  // stage 3: third weight, inside test, magnitudes
  // inside means all weights share the sign of det, so each |n| <= |det|
  always_comb begin
    n3      = N3W'(s2_det) - N3W'(s2_n1) - N3W'(s2_n2);
    n3_abs  = n3[N3W-1] ? -n3 : n3;
    n1_neg  = s2_n1[PW-1];
    n2_neg  = s2_n2[PW-1];
    n3_neg  = n3[N3W-1];
    n1_zero = (s2_n1 == '0);
    n2_zero = (s2_n2 == '0);
    n3_zero = (n3 == '0);
    in_tri  = (!n1_neg && !n2_neg && !n3_neg) ||
              ((n1_neg || n1_zero) && (n2_neg || n2_zero) && (n3_neg || n3_zero));
    degen_c = (s2_det == '0);
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_d      <= s2_det[PW-1] ? DW'(-s2_det) : DW'(s2_det);
      s3_a1     <= s2_n1[PW-1]  ? DW'(-s2_n1)  : DW'(s2_n1);
      s3_a2     <= s2_n2[PW-1]  ? DW'(-s2_n2)  : DW'(s2_n2);
      s3_a3     <= DW'(n3_abs);
      s3_cur    <= s2_cur;
      s3_degen  <= degen_c;
      s3_filled <= !degen_c && (s2_cur == '0) && in_tri;
    end
  end

  // stage 4: weights times corner values
  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_m1     <= MW'(s3_a1) * MW'(corners[0 +: bft_pkg::CORNER_W]);
      s4_m2     <= MW'(s3_a2) * MW'(corners[bft_pkg::CORNER_W +: bft_pkg::CORNER_W]);
      s4_m3     <= MW'(s3_a3) * MW'(corners[2*bft_pkg::CORNER_W +: bft_pkg::CORNER_W]);
      s4_d      <= s3_d;
      s4_cur    <= s3_cur;
      s4_filled <= s3_filled;
      s4_degen  <= s3_degen;
    end
  end

  // stage 5: scaled numerator plus half the divisor for round to nearest;
  // the blend never exceeds 255 |det|, so the top DW bits start below |det|
  always_comb begin
    num_sum  = SUMW'(s4_m1) + SUMW'(s4_m2) + SUMW'(s4_m3);
    dividend = (NW'(num_sum[MW-1:0]) << FRAC_BITS) + NW'(s4_d >> 1);
  end

  function automatic div_t div_step(div_t st);
    div_t          nxt;
    logic [DW:0]   t;
    logic          ge;
    nxt      = st;
    t        = {st.rem, st.low[QB-1]};
    ge       = (t >= {1'b0, st.dvs});
    nxt.rem  = ge ? DW'(t - {1'b0, st.dvs}) : t[DW-1:0];
    nxt.low  = {st.low[QB-2:0], ge};
    return nxt;
  endfunction

  // divider chain: one quotient bit per stage
  always_ff @(posedge clk) begin
    if (adv[5]) begin
      dv[0].rem       <= dividend[NW-1:QB];
      dv[0].low       <= dividend[QB-1:0];
      dv[0].dvs       <= s4_d;
      dv[0].pix_value <= s4_cur;
      dv[0].filled    <= s4_filled;
      dv[0].degen     <= s4_degen;
    end
    for (int j = 0; j < QB; j++) begin
      if (adv[6+j]) begin
        dv[j+1] <= div_step(dv[j]);
      end
    end
  end

  // output stage: saturate the quotient, pick fill or pass-through
  always_comb begin
    q_ext = QW'(dv[QB].low);
    q_sat = (q_ext > QW'(bft_pkg::VALUE_MAX));
  end

  always_ff @(posedge clk) begin
    if (adv[NS-1]) begin
      if (dv[QB].filled) begin
        m_tdata <= q_sat ? bft_pkg::VALUE_MAX : q_ext[VW-1:0];
      end else begin
        m_tdata <= dv[QB].pix_value;
      end
      m_tuser[bft_pkg::USER_FILLED] <= dv[QB].filled;
      m_tuser[bft_pkg::USER_DEGEN]  <= dv[QB].degen;
    end
  end

endmodule

@@ sv/bft_checker.sv @@
// port-level checks for barycentric_triangle_fill, attached by bind
// depends on bft_pkg and on the top-level port list
module bft_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [bft_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic [bft_pkg::OUT_TUSER_W-1:0] m_tuser
);

  // a held output word keeps its value until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed while stalled");

  // a degenerate triangle never fills
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[bft_pkg::USER_FILLED] && m_tuser[bft_pkg::USER_DEGEN]))
    else $error("filled and degenerate both set");

  // input is never held off while the output can move
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tready || !m_tvalid) |-> s_tready)
    else $error("input stalled with room in the pipe");

  // reset empties the pipe
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind barycentric_triangle_fill bft_checker u_bft_checker (.*);

@@ sim/barycentric_triangle_fill_tb.sv @@
// self-checking testbench for barycentric_triangle_fill: pixel words in, filled words out
// depends on bft_pkg and the block; predicts every output word and compares field by field

typedef struct packed {
  logic [15:0] new_value;
  logic        was_filled;
  logic        degenerate;
} fill_word_t;

class fill_scoreboard;
  logic [11:0] ax, ay, bx, by, cx, cy;
  logic [23:0] corners;
  fill_word_t  pending_fills[$];
  int          errors;

  function new();
    ax = '0; ay = '0; bx = '0; by = '0; cx = '0; cy = '0;
    corners = '0;
    errors = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [23:0] val);
    case (idx)
      bft_pkg::REG_VERTEX_A_X:    ax = val[11:0];
      bft_pkg::REG_VERTEX_A_Y:    ay = val[11:0];
      bft_pkg::REG_VERTEX_B_X:    bx = val[11:0];
      bft_pkg::REG_VERTEX_B_Y:    by = val[11:0];
      bft_pkg::REG_VERTEX_C_X:    cx = val[11:0];
      bft_pkg::REG_VERTEX_C_Y:    cy = val[11:0];
      bft_pkg::REG_CORNER_VALUES: corners = val;
      default: ;
    endcase
  endfunction

  // which side of the edge u->v the point lies on
  function longint side(longint px, longint py, longint ux, longint uy, longint vx, longint vy);
    return (px - vx) * (uy - vy) - (ux - vx) * (py - vy);
  endfunction

  function fill_word_t blend_pixel(logic [11:0] px_in, logic [11:0] py_in, logic [15:0] cur);
    longint xa, ya, xb, yb, xc, yc, px, py;
    longint det, e1, e2, e3, n1, n2, n3, num, d, q, va, vb, vc;
    fill_word_t w;
    xa = longint'(ax); ya = longint'(ay);
    xb = longint'(bx); yb = longint'(by);
    xc = longint'(cx); yc = longint'(cy);
    px = longint'(px_in); py = longint'(py_in);
    w.new_value  = cur;
    w.was_filled = 1'b0;
    w.degenerate = 1'b0;
    det = (yb - yc) * (xa - xc) + (xc - xb) * (ya - yc);
    if (det == 0) begin
      w.degenerate = 1'b1;
      return w;
    end
    if (cur != 0) return w;
    e1 = side(px, py, xa, ya, xb, yb);
    e2 = side(px, py, xb, yb, xc, yc);
    e3 = side(px, py, xc, yc, xa, ya);
    if (!((e1 <= 0 && e2 <= 0 && e3 <= 0) || (e1 >= 0 && e2 >= 0 && e3 >= 0))) return w;
    va = longint'(corners[7:0]);
    vb = longint'(corners[15:8]);
    vc = longint'(corners[23:16]);
    n1 = (yb - yc) * (px - xc) + (xc - xb) * (py - yc);
    n2 = (yc - ya) * (px - xc) + (xa - xc) * (py - yc);
    n3 = det - n1 - n2;
    num = n1 * va + n2 * vb + n3 * vc;
    if (num < 0) num = -num;
    d = (det < 0) ? -det : det;
    // scale to Q8.8 and round halves up
    q = ((num <<< bft_pkg::FRAC_BITS_DEF) + d / 2) / d;
    w.new_value  = (q > longint'(bft_pkg::VALUE_MAX)) ? bft_pkg::VALUE_MAX : q[15:0];
    w.was_filled = 1'b1;
    return w;
  endfunction

  function void note_pixel(logic [39:0] word);
    pending_fills.push_back(blend_pixel(word[11:0], word[23:12], word[39:24]));
  endfunction

  function void check_word(logic [15:0] data, logic [1:0] user);
    fill_word_t e;
    if (pending_fills.size() == 0) begin
      $error("output word with no pixel waiting: new_value %h", data);
      errors++;
      return;
    end
    e = pending_fills.pop_front();
    if (data !== e.new_value) begin
      $error("new_value: expected %h, got %h", e.new_value, data);
      errors++;
    end
    if (user[bft_pkg::USER_FILLED] !== e.was_filled) begin
      $error("was_filled: expected %b, got %b", e.was_filled, user[bft_pkg::USER_FILLED]);
      errors++;
    end
    if (user[bft_pkg::USER_DEGEN] !== e.degenerate) begin
      $error("degenerate: expected %b, got %b", e.degenerate, user[bft_pkg::USER_DEGEN]);
      errors++;
    end
  endfunction

  function int pending();
    return pending_fills.size();
  endfunction
endclass

module barycentric_triangle_fill_tb;

  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no word moving on either side
  localparam int SETTLE_CYCLES  = 40;    // comfortably past the pipeline depth
  localparam int HOLD_CYCLES    = 150;   // long output stall, fills the pipe
  localparam int PHASES         = 10;
  localparam int PHASE_ITEMS    = 155;
  localparam int SMALL_SPAN     = 48;    // bounding box edge of a small triangle
  localparam logic [bft_pkg::CFG_ADDR_W-1:0] REG_UNMAPPED = 3'd7;

  typedef enum int {TRI_SMALL, TRI_LARGE, TRI_CORNERS, TRI_FLAT} tri_kind_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [bft_pkg::IN_TDATA_W-1:0]  s_tdata = '0;   // pixel_x[11:0], pixel_y[23:12],
                                                   // current_value[39:24]
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [bft_pkg::OUT_TDATA_W-1:0] m_tdata;        // new_value[15:0]
  logic [bft_pkg::OUT_TUSER_W-1:0] m_tuser;        // was_filled[0], degenerate[1]
  logic                            cfg_we = 1'b0;
  logic [bft_pkg::CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [bft_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

  fill_scoreboard sb;

  // stimulus knobs, percent of cycles
  int idle_pct  = 0;
  int stall_pct = 0;

  // a new hold_seq value asks the receiver for one long stall
  int hold_seq  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int quiet_cycles = 0;

  // bounding box of the current triangle, for aiming pixels
  logic [11:0] box_x_lo, box_x_hi, box_y_lo, box_y_hi;

  barycentric_triangle_fill i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: random back-pressure, plus the long hold when asked for
  always @(posedge clk) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99, 0) >= stall_pct);
    end
  end

  // monitor both sides; words are taken as they stood just before the edge
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (s_tvalid && s_tready) sb.note_pixel(s_tdata);
      if (m_tvalid && m_tready) sb.check_word(m_tdata, m_tuser);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("barycentric_triangle_fill verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // register write, one cycle with the enable up, then the enable dropped and the scoreboard updated
  task automatic write_reg(input logic [bft_pkg::CFG_ADDR_W-1:0] idx,
                           input logic [bft_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic set_triangle(input logic [11:0] xa, ya, xb, yb, xc, yc,
                              input logic [23:0] corners);
    write_reg(bft_pkg::REG_VERTEX_A_X, 24'(xa));
    write_reg(bft_pkg::REG_VERTEX_A_Y, 24'(ya));
    write_reg(bft_pkg::REG_VERTEX_B_X, 24'(xb));
    write_reg(bft_pkg::REG_VERTEX_B_Y, 24'(yb));
    write_reg(bft_pkg::REG_VERTEX_C_X, 24'(xc));
    write_reg(bft_pkg::REG_VERTEX_C_Y, 24'(yc));
    write_reg(bft_pkg::REG_CORNER_VALUES, corners);
    box_x_lo = (xa < xb) ? xa : xb;
    box_x_lo = (xc < box_x_lo) ? xc : box_x_lo;
    box_x_hi = (xa > xb) ? xa : xb;
    box_x_hi = (xc > box_x_hi) ? xc : box_x_hi;
    box_y_lo = (ya < yb) ? ya : yb;
    box_y_lo = (yc < box_y_lo) ? yc : box_y_lo;
    box_y_hi = (ya > yb) ? ya : yb;
    box_y_hi = (yc > box_y_hi) ? yc : box_y_hi;
  endtask

  // offer one pixel word, with random idle cycles ahead of it
  task automatic send_pixel(input logic [11:0] x, y, input logic [15:0] v);
    while ($urandom_range(99, 0) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {v, y, x};
    do @(posedge clk); while (!s_tready);
  endtask

  // mostly unfilled pixels inside the bounding box, some anywhere, some already filled
  task automatic send_random_pixel();
    logic [11:0] x, y;
    logic [15:0] v;
    int          pick;
    if ($urandom_range(99, 0) < 80) begin
      x = 12'($urandom_range(box_x_hi, box_x_lo));
      y = 12'($urandom_range(box_y_hi, box_y_lo));
    end else begin
      x = 12'($urandom);
      y = 12'($urandom);
    end
    pick = $urandom_range(99, 0);
    if (pick < 65) v = '0;
    else if (pick < 95) v = 16'($urandom_range(16'hFFFF, 1));
    else v = 16'hFFFF;
    send_pixel(x, y, v);
  endtask

  // stop offering and let every expected word come back, then let the pipe settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_triangle(input tri_kind_t kind, input logic [23:0] corners);
    logic [11:0] x0, y0, dx, dy;
    case (kind)
      TRI_SMALL: begin
        x0 = 12'($urandom_range(4095 - SMALL_SPAN, 0));
        y0 = 12'($urandom_range(4095 - SMALL_SPAN, 0));
        set_triangle(12'(x0 + $urandom_range(SMALL_SPAN, 0)),
                     12'(y0 + $urandom_range(SMALL_SPAN, 0)),
                     12'(x0 + $urandom_range(SMALL_SPAN, 0)),
                     12'(y0 + $urandom_range(SMALL_SPAN, 0)),
                     12'(x0 + $urandom_range(SMALL_SPAN, 0)),
                     12'(y0 + $urandom_range(SMALL_SPAN, 0)),
                     corners);
      end
      TRI_LARGE: begin
        set_triangle(12'($urandom), 12'($urandom), 12'($urandom),
                     12'($urandom), 12'($urandom), 12'($urandom), corners);
      end
      TRI_CORNERS: begin
        // right triangle over the full range, either winding
        if ($urandom_range(1, 0) == 1) set_triangle(0, 0, 12'hFFF, 0, 0, 12'hFFF, corners);
        else set_triangle(12'hFFF, 12'hFFF, 0, 12'hFFF, 12'hFFF, 0, corners);
      end
      default: begin
        // three distinct points on one line, zero determinant
        x0 = 12'($urandom_range(4095 - 2 * SMALL_SPAN, 0));
        y0 = 12'($urandom_range(4095 - 2 * SMALL_SPAN, 0));
        dx = 12'($urandom_range(SMALL_SPAN, 1));
        dy = 12'($urandom_range(SMALL_SPAN, 0));
        set_triangle(x0, y0, 12'(x0 + dx), 12'(y0 + dy),
                     12'(x0 + 2 * dx), 12'(y0 + 2 * dy), corners);
      end
    endcase
  endtask

  initial begin
    tri_kind_t   kind;
    logic [23:0] corners;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset every vertex sits at the origin: all pixels degenerate
    send_pixel(0, 0, 0);
    send_pixel(12'hFFF, 12'hFFF, 16'hFFFF);
    drain();
    // the unmapped register index must change nothing
    write_reg(REG_UNMAPPED, 24'hFFFFFF);
    send_pixel(12'h800, 12'h7FF, 0);
    drain();

    // right triangle spanning the whole coordinate range
    set_triangle(0, 0, 12'hFFF, 0, 0, 12'hFFF, 24'h8000FF);
    send_pixel(0, 0, 0);                     // first vertex
    send_pixel(12'hFFF, 0, 0);               // second vertex
    send_pixel(0, 12'hFFF, 0);               // third vertex
    send_pixel(12'h7FF, 12'h800, 0);         // on the long edge
    send_pixel(0, 12'h7D0, 0);               // on the left edge
    send_pixel(12'h3E8, 12'h3E8, 0);         // interior
    send_pixel(12'h3E8, 12'h3E8, 16'h1234);  // already filled
    send_pixel(12'h3E8, 12'h3E8, 16'hFFFF);  // already filled, full scale
    send_pixel(12'hFFF, 12'hFFF, 0);         // far outside
    send_pixel(12'hFFF, 12'h001, 0);         // just past the long edge
    drain();

    // same triangle wound the other way, corner values at their maximum
    set_triangle(0, 0, 0, 12'hFFF, 12'hFFF, 0, 24'hFFFFFF);
    send_pixel(12'h3E8, 12'h7D0, 0);
    send_pixel(12'h7FF, 12'h800, 0);
    send_pixel(12'h800, 12'h800, 0);
    send_pixel(12'h001, 12'h001, 16'h0001);
    drain();
    write_reg(REG_UNMAPPED, 24'h000000);
    send_pixel(12'h3E8, 12'h7D0, 0);
    drain();

    // collinear but distinct vertices
    set_triangle(10, 10, 20, 20, 12'hFFF, 12'hFFF, 24'h123456);
    send_pixel(15, 15, 0);
    send_pixel(100, 5, 0);
    drain();

    // random phases: new triangle each time, idling pattern rotates through four modes
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        1, 6:    kind = TRI_LARGE;
        3, 8:    kind = TRI_CORNERS;
        5:       kind = TRI_FLAT;
        default: kind = TRI_SMALL;
      endcase
      case (ph)
        3:       corners = 24'hFFFFFF;
        8:       corners = 24'h000000;
        default: corners = 24'($urandom);
      endcase
      random_triangle(kind, corners);
      case (ph % 4)
        0: begin
          idle_pct = 0;
          stall_pct <= 0;
          // long output stall while pixels keep coming: input must back up
          hold_seq <= hold_seq + 1;
        end
        1: begin
          idle_pct = 54;
          stall_pct <= 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct <= 54;
        end
        default: begin
          idle_pct = 15;
          stall_pct <= 15;
        end
      endcase
      repeat (PHASE_ITEMS) send_random_pixel();
      drain();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("barycentric_triangle_fill verification clean");
    end else begin
      $display("barycentric_triangle_fill verification failed");
    end
    $finish;
  end

endmodule
